### src/bresenham_circle_generator_macros.svh
// Assertion macros for the circle generator checker.
// Used by the checker file only; needs clk and rst in the including scope.
`ifndef BRESENHAM_CIRCLE_GENERATOR_MACROS_SVH
`define BRESENHAM_CIRCLE_GENERATOR_MACROS_SVH

// Antecedent this cycle implies consequent next cycle
`define BCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Antecedent this cycle implies signal unchanged next cycle
`define BCG_ASSERT_HOLD(lbl, ante, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> $stable(sig)) \
    else $error("hold check failed");

`endif

### src/bcg_pkg.sv
// Shared types and constants for the circle generator.
// No dependencies; imported by every RTL module.
package bcg_pkg;

  localparam int COORD_W   = 10;
  localparam int RADIUS_W  = 9;
  localparam int OFFY_W    = 11;
  localparam int DEC_W     = 13;
  localparam int PIX_W     = 12;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PIX_PER_GROUP = 8;
  localparam int PIXCNT_W  = $clog2(PIX_PER_GROUP);

  // action codes carried on tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // One group of eight mirrored pixels, ready to be plotted
  typedef struct packed {
    logic [COORD_W-1:0]       origin_x;
    logic [COORD_W-1:0]       origin_y;
    logic [COORD_W-1:0]       offset_x;
    logic signed [OFFY_W-1:0] offset_y;
    logic                     done;
  } bcg_group_t;

endpackage

### src/bresenham_circle_generator.sv
// Midpoint circle rasterizer: a start or a live step request yields eight pixels.
// Path: queue entry, then group register, then output register for its pixels.
// Throughput: one pixel per cycle when the output is not stalled, set by the single
// output register; the front end runs ahead through a 2-entry queue.
// Steps on a finished or unstarted circle are accepted and produce nothing.
// Reset: synchronous, active high; clears circle state, queue and output valid.
module bresenham_circle_generator
  import bcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // center_x[9:0], center_y[19:10], radius[28:20]
  input  logic                  s_tuser,  // action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // pixel_x[11:0], pixel_y[23:12]
  output logic                  m_tlast,  // last_of_step
  output logic                  m_tuser   // circle_done
);

  logic       push;
  logic       push_ok;
  bcg_group_t push_group;
  logic       pop;
  logic       head_valid;
  bcg_group_t head;

  assign s_tready = push_ok;

  // Accept and classify requests
  bcg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_action   (s_tuser),
    .in_center_x (s_tdata[COORD_W-1:0]),
    .in_center_y (s_tdata[2*COORD_W-1:COORD_W]),
    .in_radius   (s_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W]),
    .push_ok     (push_ok),
    .push        (push),
    .push_group  (push_group)
  );

  // Buffer groups between the two sides
  bcg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .push_ok    (push_ok),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Plot eight pixels per group
  bcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_last   (m_tlast),
    .out_done   (m_tuser)
  );

endmodule

### src/bcg_front.sv
// Front end: accepts start/step requests, runs the midpoint update.
// Depends on bcg_pkg; feeds bcg_queue with one group per drawing request.
module bcg_front
  import bcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_action,
  input  logic [COORD_W-1:0]    in_center_x,
  input  logic [COORD_W-1:0]    in_center_y,
  input  logic [RADIUS_W-1:0]   in_radius,
  input  logic                  push_ok,
  output logic                  push,
  output bcg_group_t            push_group
);

  logic [COORD_W-1:0]       offset_x;
  logic signed [OFFY_W-1:0] offset_y;
  logic signed [DEC_W-1:0]  decision;
  logic [COORD_W-1:0]       origin_x;
  logic [COORD_W-1:0]       origin_y;
  logic                     drawing_active;

  logic                     accept;
  logic                     can_step;
  logic [COORD_W-1:0]       x_next;
  logic signed [OFFY_W-1:0] y_next;
  logic signed [DEC_W-1:0]  d_next;
  logic signed [DEC_W-1:0]  x_ext;
  logic signed [DEC_W-1:0]  diff;
  logic signed [DEC_W-1:0]  d_start;
  logic                     done_next;

  assign accept   = in_valid && push_ok;
  assign can_step = drawing_active &&
                    !(offset_y < $signed({1'b0, offset_x}));

  // Midpoint update for one step
  always_comb begin
    x_next = offset_x + COORD_W'(1);
    x_ext  = $signed({{(DEC_W-COORD_W){1'b0}}, x_next});
    if (decision > 0) begin
      y_next = offset_y - OFFY_W'(1);
      diff   = x_ext - DEC_W'(y_next);
      d_next = decision + (diff <<< 2) + DEC_W'(10);
    end else begin
      y_next = offset_y;
      diff   = x_ext - DEC_W'(offset_y);
      d_next = decision + (x_ext <<< 2) + DEC_W'(6);
    end
    done_next = y_next < $signed({1'b0, x_next});
    d_start   = DEC_W'(3) - DEC_W'({in_radius, 1'b0});
  end

  // Group sent to the queue
  always_comb begin
    push = 1'b0;
    push_group.origin_x = origin_x;
    push_group.origin_y = origin_y;
    push_group.offset_x = x_next;
    push_group.offset_y = y_next;
    push_group.done     = done_next;
    if (accept) begin
      if (in_action == ACT_START) begin
        push = 1'b1;
        push_group.origin_x = in_center_x;
        push_group.origin_y = in_center_y;
        push_group.offset_x = '0;
        push_group.offset_y = $signed({2'b00, in_radius});
        push_group.done     = 1'b0;
      end else begin
        push = can_step;
      end
    end
  end

  // Update circle state
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x       <= '0;
      offset_y       <= '0;
      decision       <= '0;
      origin_x       <= '0;
      origin_y       <= '0;
      drawing_active <= 1'b0;
    end else if (accept) begin
      if (in_action == ACT_START) begin
        origin_x       <= in_center_x;
        origin_y       <= in_center_y;
        offset_x       <= '0;
        offset_y       <= $signed({2'b00, in_radius});
        decision       <= d_start;
        drawing_active <= 1'b1;
      end else if (can_step) begin
        offset_x       <= x_next;
        offset_y       <= y_next;
        decision       <= d_next;
        drawing_active <= !done_next;
      end
    end
  end

endmodule

### src/bcg_queue.sv
// Short group queue between front end and pixel back end.
// Depends on bcg_pkg for the group type and depth.
module bcg_queue
  import bcg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bcg_group_t push_group,
  output logic       push_ok,
  input  logic       pop,
  output logic       head_valid,
  output bcg_group_t head
);

  bcg_group_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign push_ok    = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  // Store incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_group;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### src/bcg_back.sv
// Back end: expands each group into eight mirrored pixels, one per cycle unless stalled.
// Depends on bcg_pkg; drains bcg_queue and drives the output register.
module bcg_back
  import bcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  bcg_group_t            head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last,
  output logic                  out_done
);

  bcg_group_t          grp;
  logic                grp_valid;
  logic [PIXCNT_W-1:0] pix;

  logic                advance;
  logic                last_pix;
  logic [PIX_W-1:0]    off_a;
  logic [PIX_W-1:0]    off_b;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;

  assign advance  = !out_valid || out_ready;
  assign last_pix = pix == PIXCNT_W'(PIX_PER_GROUP - 1);
  assign pop      = head_valid && (!grp_valid || (advance && last_pix));

  // Mirror the offsets: bit 2 swaps x/y, bit 1 negates row, bit 0 negates column
  always_comb begin
    if (pix[2]) begin
      off_a = PIX_W'(grp.offset_y);
      off_b = {{(PIX_W-COORD_W){1'b0}}, grp.offset_x};
    end else begin
      off_a = {{(PIX_W-COORD_W){1'b0}}, grp.offset_x};
      off_b = PIX_W'(grp.offset_y);
    end
    pixel_x = {{(PIX_W-COORD_W){1'b0}}, grp.origin_x} + (pix[0] ? -off_a : off_a);
    pixel_y = {{(PIX_W-COORD_W){1'b0}}, grp.origin_y} + (pix[1] ? -off_b : off_b);
  end

  // Hold current group and pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      pix       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= grp_valid;
      end
      if (pop) begin
        grp_valid <= 1'b1;
        pix       <= '0;
      end else if (advance && grp_valid) begin
        pix <= pix + PIXCNT_W'(1);
        if (last_pix) begin
          grp_valid <= 1'b0;
        end
      end
    end
  end

  // Group payload
  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (advance && grp_valid) begin
      out_data <= {pixel_y, pixel_x};
      out_last <= last_pix;
      out_done <= grp.done;
    end
  end

endmodule

### src/bcg_checker.sv
// Port-level checker for the circle generator, bound to the top level.
// Depends on bcg_pkg and the assertion macros header.
`include "bresenham_circle_generator_macros.svh"

module bcg_checker
  import bcg_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  m_tuser
);

  logic out_stall;
  logic mid_group;

  assign out_stall = m_tvalid && !m_tready;
  assign mid_group = m_tvalid && m_tready && !m_tlast;

  // Stalled pixel stays offered and unchanged
  `BCG_ASSERT_NEXT(a_stall_valid, out_stall, m_tvalid)
  `BCG_ASSERT_HOLD(a_stall_data, out_stall, m_tdata)
  // Pixels of one group leave back to back
  `BCG_ASSERT_NEXT(a_group_burst, mid_group, m_tvalid)
  // Done flag is constant within a group
  `BCG_ASSERT_NEXT(a_group_done, mid_group, m_tuser == $past(m_tuser))

endmodule

bind bresenham_circle_generator bcg_checker u_bcg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

### dv/tb.sv
// Self-checking testbench for bresenham_circle_generator: drives start and step requests,
// predicts the eight mirrored pixels of each plotting request and checks them in order.
// Depends on bcg_pkg and the bresenham_circle_generator RTL.
`timescale 1ns / 100ps

module tb;
  import bcg_pkg::*;

  localparam int RANDOM_REQUESTS = 420;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_PRINTED     = 20;

  // One plotted pixel as seen on the output stream
  typedef struct {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             last_of_step;
    logic             circle_done;
  } pixel_t;

  // Circle predictor plus the queue of pixels still owed by the block
  class circle_scoreboard;
    pixel_t                   pending_pixels[$];
    logic [COORD_W-1:0]       center_x;
    logic [COORD_W-1:0]       center_y;
    logic [COORD_W-1:0]       off_x;
    logic signed [OFFY_W-1:0] off_y;
    logic signed [DEC_W-1:0]  decision;
    bit                       drawing;
    int                       mismatches;
    int                       requests_seen;
    int                       plotting_requests;
    int                       pixels_checked;
    int                       circles_closed;

    function new();
      center_x = '0;
      center_y = '0;
      off_x = '0;
      off_y = '0;
      decision = '0;
      drawing = 0;
      mismatches = 0;
      requests_seen = 0;
      plotting_requests = 0;
      pixels_checked = 0;
      circles_closed = 0;
    endfunction

    task report_mismatch(string what, int got, int want);
      if (mismatches < MAX_PRINTED)
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
    endtask

    // Queue the eight mirrored pixels of the current offsets
    function void push_octants(bit done);
      int cx, cy, dx, dy;
      int xs[8];
      int ys[8];
      pixel_t p;
      cx = int'(center_x);
      cy = int'(center_y);
      dx = int'(off_x);
      dy = int'(off_y);
      xs = '{cx + dx, cx - dx, cx + dx, cx - dx, cx + dy, cx - dy, cx + dy, cx - dy};
      ys = '{cy + dy, cy + dy, cy - dy, cy - dy, cy + dx, cy + dx, cy - dx, cy - dx};
      for (int k = 0; k < PIX_PER_GROUP; k++) begin
        p.pixel_x = xs[k][PIX_W-1:0];
        p.pixel_y = ys[k][PIX_W-1:0];
        p.last_of_step = (k == PIX_PER_GROUP - 1);
        p.circle_done = done;
        pending_pixels.push_back(p);
      end
    endfunction

    // Advance the circle state for one accepted request
    function void note_request(logic action, logic [COORD_W-1:0] cx,
                               logic [COORD_W-1:0] cy, logic [RADIUS_W-1:0] r);
      int x, y, d;
      requests_seen++;
      if (action == ACT_START) begin
        center_x = cx;
        center_y = cy;
        off_x = '0;
        off_y = OFFY_W'(r);
        decision = DEC_W'(3 - 2 * int'(r));
        drawing = 1;
        plotting_requests++;
        push_octants(0);
      end else if (drawing && off_y >= $signed({1'b0, off_x})) begin
        x = int'(off_x) + 1;
        y = int'(off_y);
        d = int'(decision);
        if (d > 0) begin
          y = y - 1;
          d = d + 4 * (x - y) + 10;
        end else begin
          d = d + 4 * x + 6;
        end
        off_x = COORD_W'(x);
        off_y = OFFY_W'(y);
        decision = DEC_W'(d);
        if (y < x) begin
          drawing = 0;
          circles_closed++;
        end
        plotting_requests++;
        push_octants(y < x);
      end
    endfunction

    // Compare one accepted pixel against the oldest expectation
    task check_pixel(logic [OUT_DATA_W-1:0] data, logic last, logic done);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", int'(data), 0);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (data[PIX_W-1:0] !== want.pixel_x)
          report_mismatch("pixel_x", int'(data[PIX_W-1:0]), int'(want.pixel_x));
        if (data[2*PIX_W-1:PIX_W] !== want.pixel_y)
          report_mismatch("pixel_y", int'(data[2*PIX_W-1:PIX_W]), int'(want.pixel_y));
        if (last !== want.last_of_step)
          report_mismatch("last_of_step", int'(last), int'(want.last_of_step));
        if (done !== want.circle_done)
          report_mismatch("circle_done", int'(done), int'(want.circle_done));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  circle_scoreboard sb = new();
  bit steady_flow = 0;
  int cycle_count = 0;

  bresenham_circle_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Bound the run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL bresenham_circle_generator");
      $finish;
    end
  end

  // Observe both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W],
                        s_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W]);
      if (m_tvalid && m_tready)
        sb.check_pixel(m_tdata, m_tlast, m_tuser);
    end
  end

  // Stall the pixel stream at random, one draw per pixel
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // Present one request after a random gap; returns at the negedge after acceptance
  task automatic send_request(logic action, logic [COORD_W-1:0] cx,
                              logic [COORD_W-1:0] cy, logic [RADIUS_W-1:0] r);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {{(IN_DATA_W - 2*COORD_W - RADIUS_W){1'b0}}, r, cy, cx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Step requests carry random, ignored fields
  task automatic send_step();
    send_request(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom));
  endtask

  // Start a circle, step it until it closes or the step budget runs out, then send extra steps
  task automatic trace_circle(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [RADIUS_W-1:0] r, int step_budget, int extra_steps);
    int n;
    n = 0;
    send_request(ACT_START, cx, cy, r);
    while (sb.drawing && n < step_budget) begin
      send_step();
      n++;
    end
    repeat (extra_steps) send_step();
  endtask

  initial begin
    int kind;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = ACT_START;
    s_tdata  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: idle step, zero radius, largest radius at both corners, tiny circles
    send_step();
    trace_circle(10'd0, 10'd0, 9'd0, 1000, 1);
    trace_circle(10'd1023, 10'd1023, 9'd511, 2, 0);
    trace_circle(10'd0, 10'd0, 9'd511, 1, 0);
    trace_circle(10'd512, 10'd300, 9'd1, 1000, 1);
    trace_circle(10'd100, 10'd200, 9'd3, 1000, 0);
    trace_circle(10'd1023, 10'd0, 9'd8, 1000, 1);

    // Random: mostly whole circles, some abandoned large ones, some noise
    while (sb.requests_seen < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 7) == 0)
        steady_flow = ~steady_flow;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        send_request(1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     RADIUS_W'($urandom));
      end else if (kind == 1) begin
        trace_circle(COORD_W'($urandom), COORD_W'($urandom),
                     RADIUS_W'($urandom_range(0, 511)), $urandom_range(0, 4), 0);
      end else begin
        trace_circle(COORD_W'($urandom), COORD_W'($urandom),
                     RADIUS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                           : $urandom_range(0, 12)),
                     1000, $urandom_range(0, 2));
      end
    end
    s_tvalid <= 1'b0;

    // Drain the pixel stream, then let any trailing step settle
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests (%0d plotting), %0d pixels checked, %0d circles closed",
             sb.requests_seen, sb.plotting_requests, sb.pixels_checked, sb.circles_closed);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("PASS bresenham_circle_generator");
    end else begin
      $display("FAIL bresenham_circle_generator");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/bcg_pkg.sv
src/bcg_front.sv
src/bcg_queue.sv
src/bcg_back.sv
src/bresenham_circle_generator.sv
src/bcg_checker.sv
dv/tb.sv
